/* src/bal_pkg.sv */
package bal_pkg;

  // Default geometry of the list.
  localparam int unsigned MaxEntriesDef = 16;
  localparam int unsigned WordBitsDef   = 32;

  // Request codes.
  typedef enum logic [2:0] {
    ACT_READ   = 3'd0,
    ACT_WRITE  = 3'd1,
    ACT_APPEND = 3'd2,
    ACT_INSERT = 3'd3,
    ACT_REMOVE = 3'd4
  } bal_action_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } bal_status_e;

  // What every cell of the chain does in the current cycle.
  typedef enum logic [1:0] {
    SH_HOLD   = 2'd0,
    SH_LOAD   = 2'd1,
    SH_INSERT = 2'd2,
    SH_REMOVE = 2'd3
  } bal_shift_e;

  // One request beat.
  typedef struct packed {
    logic [2:0]         action;
    logic [3:0]         position;
    logic signed [31:0] word_in;
  } bal_req_t;

  // One result beat.
  typedef struct packed {
    logic signed [31:0] word_out;
    logic [1:0]         status;
    logic [4:0]         entry_count;
  } bal_rsp_t;

endpackage

/* src/bounded_array_list.sv */
// Bounded array list: an ordered list of up to MAX_ENTRIES words.
// A request beat is taken at a rising edge where start_i is high and busy_o is
// low; busy_o stays low, so a new request may be issued in every cycle. The
// request reads, overwrites, appends, inserts (later entries move up) or
// removes (later entries move down, the removed word is returned).
// Each request yields exactly one result beat on rsp_o, marked by done_o in
// the cycle after acceptance; throughput is one request per cycle. The row of
// storage cells moves every entry at once, and the read port is a mux over the
// first sixteen cells.
// Every result carries the entry count after the request and a status of ok,
// index out of range or list full; failed requests change nothing and return
// a zero word.
// Reset empties the list; stored words are left as they were and are only
// read again after being written. The receiver cannot stall: each result is
// shown for exactly one cycle and must be taken then.
module bounded_array_list
  import bal_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = MaxEntriesDef,
  parameter int unsigned WORD_BITS   = WordBitsDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  output logic     busy_o,
  input  bal_req_t req_i,
  output logic     done_o,
  output bal_rsp_t rsp_o
);

  localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CMP_W = (CNT_W > 4) ? CNT_W : 4;

  logic [WORD_BITS-1:0] cell_data [MAX_ENTRIES];

  logic [CNT_W-1:0] count_q, count_d;
  logic             done_q;
  bal_rsp_t         rsp_q, rsp_d;

  logic                 accept;
  logic                 in_range;
  logic                 full;
  logic [IDX_W-1:0]     pos_idx;
  logic [IDX_W-1:0]     at;
  logic [31:0]          word_u;
  logic [WORD_BITS-1:0] word_st;
  logic [WORD_BITS-1:0] rd_word;
  bal_shift_e           mode;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Index checks and the read port of the list.
  assign in_range = CMP_W'(req_i.position) < CMP_W'(count_q);
  assign full     = count_q == CNT_W'(MAX_ENTRIES);
  assign pos_idx  = IDX_W'(req_i.position);
  assign rd_word  = cell_data[pos_idx];
  assign word_u   = req_i.word_in;
  assign word_st  = WORD_BITS'(word_u);

  // Decode the request into a shift command for the cells and a result beat.
  always_comb begin
    mode             = SH_HOLD;
    at               = pos_idx;
    count_d          = count_q;
    rsp_d.word_out   = '0;
    rsp_d.status     = ST_OK;
    if (accept) begin
      unique case (bal_action_e'(req_i.action))
        ACT_READ: begin
          if (in_range) rsp_d.word_out = 32'(rd_word);
          else rsp_d.status = ST_RANGE;
        end
        ACT_WRITE: begin
          if (in_range) mode = SH_LOAD;
          else rsp_d.status = ST_RANGE;
        end
        ACT_APPEND: begin
          if (full) begin
            rsp_d.status = ST_FULL;
          end else begin
            mode    = SH_LOAD;
            at      = IDX_W'(count_q);
            count_d = count_q + CNT_W'(1);
          end
        end
        ACT_INSERT: begin
          if (!in_range) begin
            rsp_d.status = ST_RANGE;
          end else if (full) begin
            rsp_d.status = ST_FULL;
          end else begin
            mode    = SH_INSERT;
            count_d = count_q + CNT_W'(1);
          end
        end
        ACT_REMOVE: begin
          if (!in_range) begin
            rsp_d.status = ST_RANGE;
          end else begin
            mode           = SH_REMOVE;
            rsp_d.word_out = 32'(rd_word);
            count_d        = count_q - CNT_W'(1);
          end
        end
        default: begin
          mode = SH_HOLD;
        end
      endcase
    end
    rsp_d.entry_count = 5'(count_d);
  end

  // The row of cells; each end cell feeds itself where it has no neighbour.
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic [WORD_BITS-1:0] lower, upper;
    if (i == 0) begin : g_first
      assign lower = cell_data[i];
    end else begin : g_mid_lo
      assign lower = cell_data[i-1];
    end
    if (i == MAX_ENTRIES - 1) begin : g_last
      assign upper = cell_data[i];
    end else begin : g_mid_hi
      assign upper = cell_data[i+1];
    end
    bal_cell #(
      .WORD_BITS(WORD_BITS),
      .IDX_W    (IDX_W),
      .IDX      (i)
    ) u_cell (
      .clk_i  (clk_i),
      .mode_i (mode),
      .at_i   (at),
      .word_i (word_st),
      .lower_i(lower),
      .upper_i(upper),
      .data_o (cell_data[i])
    );
  end

  // Entry count and result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (accept) rsp_q <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

/* src/bal_cell.sv */
module bal_cell
  import bal_pkg::*;
#(
  parameter int unsigned WORD_BITS = WordBitsDef,
  parameter int unsigned IDX_W     = 4,
  parameter int unsigned IDX       = 0
) (
  input  logic                 clk_i,
  input  bal_shift_e           mode_i,
  input  logic [IDX_W-1:0]     at_i,
  input  logic [WORD_BITS-1:0] word_i,
  input  logic [WORD_BITS-1:0] lower_i,
  input  logic [WORD_BITS-1:0] upper_i,
  output logic [WORD_BITS-1:0] data_o
);

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(IDX);

  logic [WORD_BITS-1:0] data_q, data_d;

  // Choose between holding, loading the new word or taking a neighbour's word.
  always_comb begin
    data_d = data_q;
    unique case (mode_i)
      SH_LOAD: begin
        if (MyIdx == at_i) data_d = word_i;
      end
      SH_INSERT: begin
        if (MyIdx == at_i) data_d = word_i;
        else if (MyIdx > at_i) data_d = lower_i;
      end
      SH_REMOVE: begin
        if (MyIdx >= at_i) data_d = upper_i;
      end
      default: data_d = data_q;
    endcase
  end

  // The stored word needs no reset: it is only read once it has been written.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

/* src/bal_checker.sv */
module bal_checker
  import bal_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = MaxEntriesDef
) (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start_i,
  input logic     busy_o,
  input bal_req_t req_i,
  input logic     done_o,
  input bal_rsp_t rsp_o
);

  logic accepted;
  assign accepted = start_i && !busy_o;

  // Every accepted request gives a result beat in the next cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accepted |=> done_o)
    else $error("request beat without result beat");

  // No result beat appears without a request beat before it.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accepted |=> !done_o)
    else $error("result beat without request beat");

  // Only the three defined status codes are reported.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rsp_o.status == ST_OK || rsp_o.status == ST_RANGE ||
                rsp_o.status == ST_FULL))
    else $error("undefined status code");

  // A failed request returns a zero word.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.status != ST_OK |-> rsp_o.word_out == '0)
    else $error("failed request returned a word");

  // A full report only comes from a list at capacity.
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.status == ST_FULL |-> rsp_o.entry_count == 5'(MAX_ENTRIES))
    else $error("full status with list below capacity");

endmodule

bind bounded_array_list bal_checker #(
  .MAX_ENTRIES(MAX_ENTRIES)
) u_bal_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start_i(start_i),
  .busy_o (busy_o),
  .req_i  (req_i),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);
